[design/rle_glyph_row_decoder_macros.svh]
// Assertion macros shared by the glyph row decoder modules.
`ifndef RLE_GLYPH_ROW_DECODER_MACROS_SVH
`define RLE_GLYPH_ROW_DECODER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define RGR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define RGR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RGR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define RGR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[design/rgr_pkg.sv]
// Types and constants of the glyph row decoder.
`default_nettype none
package rgr_pkg;

	// Largest cell size the decoder accepts in either direction.
	localparam logic [6:0] CELL_MAX = 7'd64;

	// Configuration register indexes.
	localparam logic REG_CELL_WIDTH  = 1'b0;
	localparam logic REG_CELL_HEIGHT = 1'b1;

	// Decoder phase.
	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_HEIGHT = 3'd1,
		PH_PAD1   = 3'd2,
		PH_PAD2   = 3'd3,
		PH_COUNT  = 3'd4,
		PH_SKIP   = 3'd5,
		PH_RUN    = 3'd6
	} phase_t;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_RUN       = 2'd0,
		KIND_DONE      = 2'd1,
		KIND_BAD_HDR   = 2'd2,
		KIND_EXHAUSTED = 2'd3
	} kind_t;

	// One input byte request.
	typedef struct packed {
		logic       first_byte;
		logic [7:0] data_byte;
		logic       final_byte;
	} in_item_t;

	// One result.
	typedef struct packed {
		kind_t      kind;
		logic [5:0] run_row;
		logic [5:0] run_start;
		logic [6:0] run_length;
		logic [7:0] glyph_width;
		logic [7:0] glyph_height;
		logic       last_of_run;
	} res_t;

	localparam res_t RES_ZERO = '{kind: KIND_RUN, default: '0};

endpackage
`default_nettype wire

[design/rgr_byte_if.sv]
// Channel carrying encoded glyph bytes.
`default_nettype none
interface rgr_byte_if;
	logic       valid;
	logic       ready;
	logic       first_byte;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output first_byte, output data_byte,
		output final_byte, input ready);
	modport sink (input valid, input first_byte, input data_byte,
		input final_byte, output ready);
endinterface
`default_nettype wire

[design/rgr_run_if.sv]
// Channel carrying decoded run results.
`default_nettype none
interface rgr_run_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [5:0] run_row;
	logic [5:0] run_start;
	logic [6:0] run_length;
	logic [7:0] glyph_width;
	logic [7:0] glyph_height;
	logic       last_of_run;

	modport source (output valid, output kind, output run_row, output run_start,
		output run_length, output glyph_width, output glyph_height,
		output last_of_run, input ready);
	modport sink (input valid, input kind, input run_row, input run_start,
		input run_length, input glyph_width, input glyph_height,
		input last_of_run, output ready);
endinterface
`default_nettype wire

[design/rgr_cfg_if.sv]
// Configuration write channel.
`default_nettype none
interface rgr_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [6:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[design/rgr_step.sv]
// Decoder state registers and the per-byte decode logic.
`default_nettype none
`include "rle_glyph_row_decoder_macros.svh"
module rgr_step import rgr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step_en,
	input  wire in_item_t   item,
	input  wire logic [6:0] cell_width,
	input  wire logic [6:0] cell_height,
	output logic [1:0]      res_n,
	output res_t            res0,
	output res_t            res1
);

	phase_t     phase_q, phase_d;
	logic [7:0] width_q, width_d;
	logic [7:0] height_q, height_d;
	logic [6:0] row_q, row_d;
	logic [7:0] col_q, col_d;
	logic [7:0] left_q, left_d;

	logic       a_v, b_v, exh_v;
	res_t       res_a, res_b, res_exh;
	logic [7:0] b;
	logic [7:0] left_dec;
	logic [8:0] col_sum;
	logic [7:0] col_sat;
	logic [6:0] lim_w, lim_h;
	logic       hdr_bad;
	logic [6:0] row_inc;
	logic       last_row;
	logic [7:0] avail;
	logic [7:0] run_len;
	logic       run_in;

	// Shared datapath terms.
	assign b        = item.data_byte;
	assign left_dec = left_q - 8'd1;
	assign col_sum  = {1'b0, col_q} + {1'b0, b};
	assign col_sat  = col_sum[8] ? 8'hFF : col_sum[7:0];
	assign lim_w    = (cell_width > CELL_MAX) ? CELL_MAX : cell_width;
	assign lim_h    = (cell_height > CELL_MAX) ? CELL_MAX : cell_height;
	assign hdr_bad  = (width_q == 8'd0) || (height_q == 8'd0) ||
		(width_q > {1'b0, lim_w}) || (height_q > {1'b0, lim_h});
	assign row_inc  = row_q + 7'd1;
	assign last_row = {1'b0, row_inc} >= height_q;
	assign run_in   = (b != 8'd0) && (col_q < width_q);
	assign avail    = width_q - col_q;
	assign run_len  = (b < avail) ? b : avail;

	// Next state and results of one byte.
	always_comb begin
		phase_d  = phase_q;
		width_d  = width_q;
		height_d = height_q;
		row_d    = row_q;
		col_d    = col_q;
		left_d   = left_q;
		a_v      = 1'b0;
		b_v      = 1'b0;
		res_a    = RES_ZERO;
		res_b    = RES_ZERO;
		res_exh  = RES_ZERO;
		res_exh.kind = KIND_EXHAUSTED;

		if (item.first_byte) begin
			width_d  = b;
			height_d = 8'd0;
			row_d    = 7'd0;
			col_d    = 8'd0;
			left_d   = 8'd0;
			phase_d  = PH_HEIGHT;
		end else begin
			case (phase_q)
				PH_HEIGHT: begin
					height_d = b;
					phase_d  = PH_PAD1;
				end
				PH_PAD1: begin
					phase_d = PH_PAD2;
				end
				PH_PAD2: begin
					if (hdr_bad) begin
						a_v                = 1'b1;
						res_a.kind         = KIND_BAD_HDR;
						res_a.glyph_width  = width_q;
						res_a.glyph_height = height_q;
						phase_d            = PH_IDLE;
					end else begin
						row_d   = 7'd0;
						col_d   = 8'd0;
						phase_d = PH_COUNT;
					end
				end
				PH_COUNT: begin
					left_d  = b;
					phase_d = PH_SKIP;
				end
				PH_SKIP: begin
					left_d = left_dec;
					if (left_dec == 8'd0) begin
						// A skip byte that closes the row is not applied.
						col_d = 8'd0;
						row_d = row_inc;
						if (last_row) begin
							a_v                = 1'b1;
							res_a.kind         = KIND_DONE;
							res_a.glyph_width  = width_q;
							res_a.glyph_height = height_q;
							phase_d            = PH_IDLE;
						end else begin
							phase_d = PH_COUNT;
						end
					end else begin
						col_d   = col_sat;
						phase_d = PH_RUN;
					end
				end
				PH_RUN: begin
					left_d           = left_dec;
					a_v              = 1'b1;
					res_a.kind       = KIND_RUN;
					res_a.run_row    = row_q[5:0];
					res_a.run_start  = run_in ? col_q[5:0] : 6'd0;
					res_a.run_length = run_in ? run_len[6:0] : 7'd0;
					if (left_dec == 8'd0) begin
						col_d = 8'd0;
						row_d = row_inc;
						if (last_row) begin
							b_v                = 1'b1;
							res_b.kind         = KIND_DONE;
							res_b.glyph_width  = width_q;
							res_b.glyph_height = height_q;
							phase_d            = PH_IDLE;
						end else begin
							phase_d = PH_COUNT;
						end
					end else begin
						col_d   = col_sat;
						phase_d = PH_SKIP;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end

		// Running out of bytes mid-glyph ends the glyph.
		exh_v = item.final_byte && (phase_d != PH_IDLE);
		if (exh_v) begin
			phase_d = PH_IDLE;
		end
	end

	// Pack the results in order and flag the last one.
	always_comb begin
		res0 = a_v ? res_a : res_exh;
		res1 = b_v ? res_b : res_exh;
		if (a_v) begin
			res_n = (b_v || exh_v) ? 2'd2 : 2'd1;
		end else begin
			res_n = exh_v ? 2'd1 : 2'd0;
		end
		res0.last_of_run = (res_n == 2'd1);
		res1.last_of_run = 1'b1;
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			width_q  <= 8'd0;
			height_q <= 8'd0;
			row_q    <= 7'd0;
			col_q    <= 8'd0;
			left_q   <= 8'd0;
		end else if (step_en) begin
			phase_q  <= phase_d;
			width_q  <= width_d;
			height_q <= height_d;
			row_q    <= row_d;
			col_q    <= col_d;
			left_q   <= left_d;
		end
	end

	`RGR_ASSERT_NEXT(a_exh_goes_idle, clk, arst_n, step_en && exh_v, phase_q == PH_IDLE, "exhausted byte did not leave the decoder idle")
	`RGR_ASSERT_SAME(a_idle_ignores, clk, arst_n, step_en && (phase_q == PH_IDLE) && !item.first_byte && !item.final_byte, res_n == 2'd0, "stray byte while idle produced a result")
	`RGR_ASSERT_SAME(a_two_needs_run, clk, arst_n, step_en && (res_n == 2'd2), (phase_q == PH_RUN) && !item.first_byte, "two results from a byte that is not a run byte")

endmodule
`default_nettype wire

[design/rgr_outq.sv]
// Result queue that takes up to two results a cycle and releases one.
`default_nettype none
`include "rle_glyph_row_decoder_macros.svh"
module rgr_outq import rgr_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [1:0] push_n,
	input  wire res_t       push0,
	input  wire res_t       push1,
	output logic            room,
	output logic            out_valid,
	input  wire logic       out_ready,
	output res_t            out_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

	res_t          mem_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [PW-1:0] wptr1, wptr2, rptr_inc;
	logic [CW-1:0] count_q;
	logic          pop;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		ptr_next = (p == PTR_LAST) ? '0 : p + PW'(1);
	endfunction

	// Room for a full two-result push, whatever pops this cycle.
	assign room      = count_q <= CW'(DEPTH - 2);
	assign out_valid = count_q != '0;
	assign out_data  = mem_q[rptr_q];
	assign pop       = out_valid && out_ready;
	assign wptr1     = ptr_next(wptr_q);
	assign wptr2     = ptr_next(wptr1);
	assign rptr_inc  = ptr_next(rptr_q);

	// Entry storage.
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if ((push_n != 2'd0) && (PW'(i) == wptr_q)) begin
				mem_q[i] <= push0;
			end
			if ((push_n == 2'd2) && (PW'(i) == wptr1)) begin
				mem_q[i] <= push1;
			end
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			case (push_n)
				2'd1: wptr_q <= wptr1;
				2'd2: wptr_q <= wptr2;
				default: wptr_q <= wptr_q;
			endcase
			if (pop) begin
				rptr_q <= rptr_inc;
			end
			count_q <= count_q + CW'(push_n) - CW'(pop);
		end
	end

	`RGR_ASSERT_SAME(a_no_overflow, clk, arst_n, push_n != 2'd0, ({1'b0, count_q} + (CW+1)'(push_n)) <= (CW+1)'(DEPTH), "result queue overflow")
	`RGR_ASSERT_NEXT(a_count_track, clk, arst_n, pop && (push_n == 2'd0), count_q == $past(count_q) - CW'(1), "fill count did not follow a pop")
	`RGR_ASSERT_SAME(a_head_last, clk, arst_n, count_q == CW'(1), mem_q[rptr_q].last_of_run, "lone queued result is not the last of its byte")

endmodule
`default_nettype wire

[design/rle_glyph_row_decoder.sv]
// Top level of the run-length glyph row decoder.
//
// Usage: encoded glyph bytes arrive one per request on the glyph channel,
// with first_byte marking the width byte of a new glyph and final_byte the
// last byte available. Each byte may produce zero, one or two results on the
// runs channel (pixel run, glyph done, bad header, data exhausted), in
// order; last_of_run marks the final result of a byte. The cfg channel
// writes cell_width (index 0) and cell_height (index 1); it is always ready.
// The user must write it only while the decoder is idle; the block itself
// does not enforce this. An accepted byte waits in the input register until
// the result queue has room, then is decoded and its results pushed into
// the queue, which offers them. Throughput is one byte per cycle as long as
// bytes yield at most one result each and the receiver is ready; the rate is
// set by the single output port of the result queue.
// Reset clears the decoder to idle, empties the queue and sets both cell
// registers to 64. When the receiver stalls, the queue fills and the glyph
// channel drops ready once fewer than two free entries remain.
`default_nettype none
module rle_glyph_row_decoder import rgr_pkg::*; #(
	parameter int OUTQ_DEPTH = 4
) (
	input wire logic  clk,
	input wire logic  arst_n,
	rgr_byte_if.sink  glyph,
	rgr_run_if.source runs,
	rgr_cfg_if.sink   cfg
);

	logic       valid_s1;
	in_item_t   item_s1;
	logic       advance;
	logic       room;
	logic [6:0] cell_width_q;
	logic [6:0] cell_height_q;
	logic [1:0] res_n;
	logic [1:0] push_n;
	res_t       res0, res1;
	res_t       out_data;

	// Input register: refills when empty or whenever its byte moves on.
	assign advance     = valid_s1 && room;
	assign glyph.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (glyph.ready) begin
			valid_s1 <= glyph.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (glyph.ready && glyph.valid) begin
			item_s1 <= '{first_byte: glyph.first_byte, data_byte: glyph.data_byte,
				final_byte: glyph.final_byte};
		end
	end

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_width_q  <= CELL_MAX;
			cell_height_q <= CELL_MAX;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CELL_WIDTH:  cell_width_q  <= cfg.data;
				REG_CELL_HEIGHT: cell_height_q <= cfg.data;
				default: cell_width_q <= cell_width_q;
			endcase
		end
	end

	// Decode step.
	rgr_step u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (advance),
		.item        (item_s1),
		.cell_width  (cell_width_q),
		.cell_height (cell_height_q),
		.res_n       (res_n),
		.res0        (res0),
		.res1        (res1)
	);

	assign push_n = advance ? res_n : 2'd0;

	// Result queue.
	rgr_outq #(.DEPTH(OUTQ_DEPTH)) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push0     (res0),
		.push1     (res1),
		.room      (room),
		.out_valid (runs.valid),
		.out_ready (runs.ready),
		.out_data  (out_data)
	);

	assign runs.kind         = out_data.kind;
	assign runs.run_row      = out_data.run_row;
	assign runs.run_start    = out_data.run_start;
	assign runs.run_length   = out_data.run_length;
	assign runs.glyph_width  = out_data.glyph_width;
	assign runs.glyph_height = out_data.glyph_height;
	assign runs.last_of_run  = out_data.last_of_run;

endmodule
`default_nettype wire

[verif/rle_glyph_row_decoder_tb.sv]
// Self-checking testbench for the run-length glyph row decoder.
module rle_glyph_row_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rgr_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 20;

	// Tracks decoder state, predicts the runs of each byte and checks what comes out.
	class glyph_scoreboard;
		logic [6:0] cell_w_reg;
		logic [6:0] cell_h_reg;
		phase_t     phase_q;
		logic [7:0] width_q;
		logic [7:0] height_q;
		logic [6:0] row_q;
		logic [7:0] col_q;
		logic [7:0] left_q;
		res_t       pending_runs[$];
		res_t       byte_runs[$];
		int         errors;
		int         shown;

		function void clear();
			cell_w_reg = CELL_MAX;
			cell_h_reg = CELL_MAX;
			phase_q = PH_IDLE;
			width_q = '0;
			height_q = '0;
			row_q = '0;
			col_q = '0;
			left_q = '0;
			pending_runs.delete();
			errors = 0;
			shown = 0;
		endfunction

		function void write_reg(logic idx, logic [6:0] val);
			if (idx == REG_CELL_WIDTH) begin
				cell_w_reg = val;
			end else begin
				cell_h_reg = val;
			end
		endfunction

		// Register values above the largest cell count as the largest cell.
		function logic [7:0] cap(logic [6:0] r);
			return (r > CELL_MAX) ? {1'b0, CELL_MAX} : {1'b0, r};
		endfunction

		function logic [7:0] sat_col(logic [7:0] a, logic [7:0] b);
			logic [8:0] s;
			s = {1'b0, a} + {1'b0, b};
			return (s > 9'd255) ? 8'd255 : s[7:0];
		endfunction

		function void add_result(kind_t k, logic [5:0] row, logic [5:0] start,
				logic [6:0] len, logic [7:0] w, logic [7:0] h);
			res_t r;
			r = RES_ZERO;
			r.kind = k;
			r.run_row = row;
			r.run_start = start;
			r.run_length = len;
			r.glyph_width = w;
			r.glyph_height = h;
			r.last_of_run = 1'b0;
			byte_runs.push_back(r);
		endfunction

		// A finished row either starts the next one or completes the glyph.
		function void close_row();
			col_q = '0;
			row_q = row_q + 7'd1;
			if ({1'b0, row_q} >= height_q) begin
				add_result(KIND_DONE, '0, '0, '0, width_q, height_q);
				phase_q = PH_IDLE;
			end else begin
				phase_q = PH_COUNT;
			end
		endfunction

		// Called for every accepted byte request.
		function void note_byte(logic fb, logic [7:0] b, logic fin);
			logic [7:0] start8;
			logic [7:0] rs8;
			logic [7:0] len8;
			logic [7:0] avail;
			byte_runs.delete();
			if (fb) begin
				width_q = b;
				height_q = '0;
				row_q = '0;
				col_q = '0;
				left_q = '0;
				phase_q = PH_HEIGHT;
			end else begin
				case (phase_q)
					PH_HEIGHT: begin
						height_q = b;
						phase_q = PH_PAD1;
					end
					PH_PAD1: phase_q = PH_PAD2;
					PH_PAD2: begin
						if (width_q == 0 || height_q == 0 || width_q > cap(cell_w_reg) ||
								height_q > cap(cell_h_reg)) begin
							add_result(KIND_BAD_HDR, '0, '0, '0, width_q, height_q);
							phase_q = PH_IDLE;
						end else begin
							row_q = '0;
							col_q = '0;
							phase_q = PH_COUNT;
						end
					end
					PH_COUNT: begin
						left_q = b;
						phase_q = PH_SKIP;
					end
					// A skip byte that ends the row is not added to the column.
					PH_SKIP: begin
						left_q = left_q - 8'd1;
						if (left_q == 0) begin
							close_row();
						end else begin
							col_q = sat_col(col_q, b);
							phase_q = PH_RUN;
						end
					end
					// Runs are clipped to the glyph; runs past its edge are empty.
					PH_RUN: begin
						start8 = col_q;
						rs8 = '0;
						len8 = '0;
						left_q = left_q - 8'd1;
						if (b != 0 && start8 < width_q) begin
							avail = width_q - start8;
							len8 = (b < avail) ? b : avail;
							rs8 = start8;
						end
						add_result(KIND_RUN, row_q[5:0], rs8[5:0], len8[6:0], '0, '0);
						col_q = sat_col(col_q, b);
						if (left_q == 0) begin
							close_row();
						end else begin
							phase_q = PH_SKIP;
						end
					end
					default: phase_q = PH_IDLE;
				endcase
			end
			// Running out of bytes mid-glyph follows any other result.
			if (fin && phase_q != PH_IDLE) begin
				add_result(KIND_EXHAUSTED, '0, '0, '0, '0, '0);
				phase_q = PH_IDLE;
			end
			if (byte_runs.size() > 0) begin
				byte_runs[byte_runs.size() - 1].last_of_run = 1'b1;
			end
			foreach (byte_runs[i]) begin
				pending_runs.push_back(byte_runs[i]);
			end
		endfunction

		function void report(string what, res_t want, res_t got);
			errors++;
			if (shown < 10) begin
				$display("%0t %s: expected kind=%0d row=%0d start=%0d len=%0d w=%0d h=%0d last=%0d",
					$realtime, what, want.kind, want.run_row, want.run_start, want.run_length,
					want.glyph_width, want.glyph_height, want.last_of_run);
				$display("    got kind=%0d row=%0d start=%0d len=%0d w=%0d h=%0d last=%0d",
					got.kind, got.run_row, got.run_start, got.run_length,
					got.glyph_width, got.glyph_height, got.last_of_run);
			end
			shown++;
		endfunction

		// Called for every accepted result request.
		function void check_run(res_t got);
			res_t want;
			if (pending_runs.size() == 0) begin
				report("unexpected result", RES_ZERO, got);
				return;
			end
			want = pending_runs.pop_front();
			if (got.kind !== want.kind || got.run_row !== want.run_row ||
					got.run_start !== want.run_start || got.run_length !== want.run_length ||
					got.glyph_width !== want.glyph_width ||
					got.glyph_height !== want.glyph_height ||
					got.last_of_run !== want.last_of_run) begin
				report("result mismatch", want, got);
			end
		endfunction

		function int outstanding();
			return pending_runs.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rgr_byte_if glyph_ch();
	rgr_run_if  run_ch();
	rgr_cfg_if  cfg_ch();

	rle_glyph_row_decoder dut (
		.clk   (clk),
		.arst_n(arst_n),
		.glyph (glyph_ch),
		.runs  (run_ch),
		.cfg   (cfg_ch)
	);

	glyph_scoreboard board;
	in_item_t        glyph_plan[$];
	bit              pace_free = 1'b0;
	int              hold_left = 0;
	int              sent_count = 0;
	int              cap_w = 64;
	int              cap_h = 64;
	int              cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic void plan_add(logic fb, logic [7:0] b, logic fin);
		in_item_t it;
		it.first_byte = fb;
		it.data_byte = b;
		it.final_byte = fin;
		glyph_plan.push_back(it);
	endfunction

	// Header, then rows only when the decoder will accept the header.
	function automatic void plan_glyph(int w, int h, bit wrap_row);
		int n;
		plan_add(1'b1, 8'(w), 1'b0);
		plan_add(1'b0, 8'(h), 1'b0);
		plan_add(1'b0, 8'($urandom_range(0, 255)), 1'b0);
		plan_add(1'b0, 8'($urandom_range(0, 255)), 1'b0);
		if (w < 1 || h < 1 || w > cap_w || h > cap_h) begin
			return;
		end
		for (int r = 0; r < h; r++) begin
			// A count byte of zero wraps around to a 256-byte row.
			if (wrap_row) begin
				n = 256;
			end else if ($urandom_range(0, 9) == 0) begin
				n = $urandom_range(10, 40);
			end else begin
				n = $urandom_range(1, 9);
			end
			plan_add(1'b0, 8'(n), 1'b0);
			for (int i = 0; i < n; i++) begin
				if (i % 2 == 0) begin
					plan_add(1'b0, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
						8'($urandom_range(0, w / 2)), 1'b0);
				end else begin
					plan_add(1'b0, ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
						8'($urandom_range(0, w)), 1'b0);
				end
			end
		end
	endfunction

	// Offers one byte request, after a random gap unless pace_free is set; returns at the next falling edge.
	task automatic put_byte(in_item_t it);
		int gap;
		gap = pace_free ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			glyph_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		glyph_ch.valid <= 1'b1;
		glyph_ch.first_byte <= it.first_byte;
		glyph_ch.data_byte <= it.data_byte;
		glyph_ch.final_byte <= it.final_byte;
		do @(posedge clk); while (!glyph_ch.ready);
		board.note_byte(it.first_byte, it.data_byte, it.final_byte);
		@(negedge clk);
	endtask

	task automatic play_plan(bit counted);
		foreach (glyph_plan[i]) begin
			put_byte(glyph_plan[i]);
			if (counted) begin
				sent_count++;
			end
		end
		glyph_plan.delete();
	endtask

	// Stop offering bytes and wait until every expected result has come.
	task automatic settle();
		glyph_ch.valid <= 1'b0;
		while (board.outstanding() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_cells(logic [6:0] w, logic [6:0] h);
		for (int i = 0; i < 2; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= (i == 0) ? REG_CELL_WIDTH : REG_CELL_HEIGHT;
			cfg_ch.data <= (i == 0) ? w : h;
			do @(posedge clk); while (!cfg_ch.ready);
			board.write_reg((i == 0) ? REG_CELL_WIDTH : REG_CELL_HEIGHT, (i == 0) ? w : h);
			@(negedge clk);
		end
		cfg_ch.valid <= 1'b0;
		cap_w = (w > CELL_MAX) ? int'(CELL_MAX) : int'(w);
		cap_h = (h > CELL_MAX) ? int'(CELL_MAX) : int'(h);
	endtask

	// Random glyph, sometimes cut short by a final byte or by a new glyph.
	task automatic random_glyph();
		int w;
		int h;
		int k;
		int pick;
		if ($urandom_range(0, 9) == 0 || cap_w == 0) begin
			w = $urandom_range(0, 255);
		end else begin
			w = $urandom_range(1, cap_w);
		end
		if ($urandom_range(0, 9) == 0 || cap_h == 0) begin
			h = $urandom_range(0, 255);
		end else if ($urandom_range(0, 7) == 0) begin
			h = $urandom_range(1, cap_h);
		end else begin
			h = $urandom_range(1, (cap_h < 3) ? cap_h : 3);
		end
		plan_glyph(w, h, 1'b0);
		pick = $urandom_range(0, 99);
		k = $urandom_range(0, glyph_plan.size() - 1);
		if (pick < 12) begin
			glyph_plan[k].final_byte = 1'b1;
			while (glyph_plan.size() > k + 1) glyph_plan.pop_back();
		end else if (pick < 22 && k > 0) begin
			while (glyph_plan.size() > k) glyph_plan.pop_back();
		end else if (pick < 32) begin
			glyph_plan[glyph_plan.size() - 1].final_byte = 1'b1;
		end
		play_plan(1'b1);
	endtask

	// Result side: random stalls, plus one long hold-off on request.
	initial begin : run_sink
		int   stall;
		res_t got;
		run_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = pace_free ? 0 : $urandom_range(0, 4);
			if (hold_left > 0) begin
				stall = hold_left;
				hold_left = 0;
			end
			if (stall > 0) begin
				run_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			run_ch.ready <= 1'b1;
			do @(posedge clk); while (!run_ch.valid);
			got.kind = kind_t'(run_ch.kind);
			got.run_row = run_ch.run_row;
			got.run_start = run_ch.run_start;
			got.run_length = run_ch.run_length;
			got.glyph_width = run_ch.glyph_width;
			got.glyph_height = run_ch.glyph_height;
			got.last_of_run = run_ch.last_of_run;
			board.check_run(got);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		logic [6:0] nw;
		logic [6:0] nh;
		int         pick;
		glyph_ch.valid <= 1'b0;
		glyph_ch.first_byte <= 1'b0;
		glyph_ch.data_byte <= '0;
		glyph_ch.final_byte <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_CELL_WIDTH;
		cfg_ch.data <= '0;
		board = new;
		board.clear();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: a stray byte while idle is ignored.
		plan_add(1'b0, 8'hA5, 1'b0);
		// Smallest glyph, with the final byte on the byte that completes it.
		plan_add(1'b1, 8'd1, 1'b0);
		plan_add(1'b0, 8'd1, 1'b0);
		plan_add(1'b0, 8'd0, 1'b0);
		plan_add(1'b0, 8'd0, 1'b0);
		plan_add(1'b0, 8'd2, 1'b0);
		plan_add(1'b0, 8'd0, 1'b0);
		plan_add(1'b0, 8'd1, 1'b1);
		// Zero width: bad header wins over exhaustion on the fourth byte.
		plan_add(1'b1, 8'd0, 1'b0);
		plan_add(1'b0, 8'd5, 1'b0);
		plan_add(1'b0, 8'hFF, 1'b0);
		plan_add(1'b0, 8'hFF, 1'b1);
		// Final byte on the width byte.
		plan_add(1'b1, 8'd40, 1'b1);
		// Header abandoned by a new glyph.
		plan_add(1'b1, 8'd3, 1'b0);
		plan_add(1'b0, 8'd3, 1'b0);
		// Full width glyph: runs past the edge, column saturation, clipping.
		plan_add(1'b1, 8'd64, 1'b0);
		plan_add(1'b0, 8'd2, 1'b0);
		plan_add(1'b0, 8'd0, 1'b0);
		plan_add(1'b0, 8'd0, 1'b0);
		plan_add(1'b0, 8'd4, 1'b0);
		plan_add(1'b0, 8'd200, 1'b0);
		plan_add(1'b0, 8'd100, 1'b0);
		plan_add(1'b0, 8'd255, 1'b0);
		plan_add(1'b0, 8'd0, 1'b0);
		plan_add(1'b0, 8'd3, 1'b0);
		plan_add(1'b0, 8'd10, 1'b0);
		plan_add(1'b0, 8'd255, 1'b0);
		plan_add(1'b0, 8'd7, 1'b0);
		play_plan(1'b0);

		// Random phases, each under its own cell size.
		for (int p = 0; p < 6; p++) begin
			settle();
			case (p)
				0: begin nw = 7'd64; nh = 7'd64; end
				1: begin nw = 7'd1; nh = 7'd1; end
				2: begin nw = 7'd127; nh = 7'd100; end
				3: begin nw = 7'd0; nh = 7'd0; end
				default: begin
					nw = 7'($urandom_range(1, 64));
					nh = 7'($urandom_range(1, 64));
				end
			endcase
			write_cells(nw, nh);
			if (p == 0) begin
				// Hold the result side off while bytes keep coming, so the queue fills.
				pace_free = 1'b1;
				hold_left = 60;
				plan_glyph(64, 4, 1'b0);
				play_plan(1'b1);
				settle();
				pace_free = 1'b0;
				// One row whose count byte wraps.
				plan_glyph(16, 1, 1'b1);
				play_plan(1'b1);
			end
			sent_count = 0;
			while (sent_count < PHASE_ITEMS) begin
				pick = $urandom_range(0, 19);
				if (pick == 0) begin
					// Noise bytes, sent while idle or after a glyph that is still open.
					settle();
					repeat ($urandom_range(1, 3)) begin
						plan_add(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
					end
					play_plan(1'b0);
				end else if (pick == 1) begin
					pace_free = !pace_free;
				end else begin
					random_glyph();
				end
			end
			pace_free = 1'b0;
		end

		settle();
		repeat (8) @(negedge clk);
		board.errors += board.outstanding();
		if (board.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+design
design/rgr_pkg.sv
design/rgr_byte_if.sv
design/rgr_run_if.sv
design/rgr_cfg_if.sv
design/rgr_step.sv
design/rgr_outq.sv
design/rle_glyph_row_decoder.sv
verif/rle_glyph_row_decoder_tb.sv
